// ----- design/tfc_pkg.sv -----
// Shared types, constants and the bytewise CRC-16/CCITT-FALSE update
// for the telemetry frame checker. No dependencies.
`timescale 1ns / 1ps

package tfc_pkg;

    localparam logic [5:0]  FRAME_BYTES   = 6'd43;
    localparam logic [5:0]  POS_SYNC      = 6'd0;
    localparam logic [5:0]  POS_VERSION   = 6'd1;
    localparam logic [5:0]  POS_PAYLOAD   = 6'd2;
    localparam logic [5:0]  POS_CRC_LAST  = FRAME_BYTES - 6'd3;
    localparam logic [5:0]  POS_CHECK_LO  = FRAME_BYTES - 6'd2;
    localparam logic [5:0]  POS_CHECK_HI  = FRAME_BYTES - 6'd1;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    localparam logic [7:0]  SYNC_RESET    = 8'hA5;
    localparam logic [7:0]  VERSION_RESET = 8'h01;

    // Configuration register indexes
    localparam logic        CFG_SYNC      = 1'b0;
    localparam logic        CFG_VERSION   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_SYNC    = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_CRC     = 3'd4
    } status_t;

    typedef struct packed {
        logic       payload_valid;
        logic [5:0] payload_offset;
        logic [7:0] payload_byte;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

    // MSB-first CRC over one byte, eight shift steps on 16 bits
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- design/tfc_frame_track.sv -----
// Frame position tracking, sync/version checks, running CRC and status.
// Depends on tfc_pkg.
`timescale 1ns / 1ps

module tfc_frame_track
    import tfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    input  logic [7:0] sync_value,
    input  logic [7:0] version_value,
    output result_t    result
);

    logic [5:0]  count_reg,   count_next;
    logic [15:0] crc_reg,     crc_next;
    logic        sync_ok_reg, sync_ok_next;
    logic        ver_ok_reg,  ver_ok_next;
    logic [15:0] check_reg,   check_next;
    logic        in_frame;

    assign in_frame = (count_reg < FRAME_BYTES);

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        sync_ok_next = sync_ok_reg;
        ver_ok_next  = ver_ok_reg;
        check_next   = check_reg;
        result       = '0;

        if (accept)
        begin
            // bytes beyond the frame length change nothing unless they end the frame
            if (in_frame)
            begin
                if (count_reg == POS_SYNC)
                begin
                    sync_ok_next = (rx_byte == sync_value);
                end
                if (count_reg == POS_VERSION)
                begin
                    ver_ok_next = (rx_byte == version_value);
                end
                if (count_reg <= POS_CRC_LAST)
                begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                end
                if (count_reg >= POS_PAYLOAD && count_reg <= POS_CRC_LAST)
                begin
                    result.payload_valid  = 1'b1;
                    result.payload_offset = count_reg - POS_PAYLOAD;
                    result.payload_byte   = rx_byte;
                end
                if (count_reg == POS_CHECK_LO)
                begin
                    check_next = {check_reg[15:8], rx_byte};
                end
                if (count_reg == POS_CHECK_HI)
                begin
                    check_next = {rx_byte, check_reg[7:0]};
                end
                count_next = count_reg + 6'd1;
            end

            if (last_byte)
            begin
                result.frame_done = 1'b1;
                if (count_next < FRAME_BYTES)
                begin
                    result.frame_status = ST_SHORT;
                end
                else if (!sync_ok_next)
                begin
                    result.frame_status = ST_BAD_SYNC;
                end
                else if (!ver_ok_next)
                begin
                    result.frame_status = ST_BAD_VERSION;
                end
                else if (crc_next != check_next)
                begin
                    result.frame_status = ST_BAD_CRC;
                end
                else
                begin
                    result.frame_status = ST_OK;
                end
                // re-arm for the next frame
                count_next   = '0;
                crc_next     = CRC_INIT;
                sync_ok_next = 1'b0;
                ver_ok_next  = 1'b0;
                check_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            sync_ok_reg <= 1'b0;
            ver_ok_reg  <= 1'b0;
            check_reg   <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            sync_ok_reg <= sync_ok_next;
            ver_ok_reg  <= ver_ok_next;
            check_reg   <= check_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FRAME_BYTES)
        else $error("frame byte count beyond frame length");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> count_reg == '0 && crc_reg == CRC_INIT && !sync_ok_reg)
        else $error("state not re-armed after last byte");

    a_sat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte && !in_frame |=> $stable(crc_reg) && $stable(check_reg))
        else $error("extra byte changed frame state");
`endif

endmodule

// ----- design/telemetry_frame_checker_crc16_unit.sv -----
// A result item appears on m_tvalid in the cycle after its input item is accepted.
// Throughput: one item per cycle while m_tready is high; the single result register refills in the cycle it drains.
// The CRC for each byte is an eight-step XOR network between input and CRC register.
// Reset (rst_n low, asynchronous): frame state re-armed, no result held,
// sync register 0xA5, version register 0x01.
// Top level of the telemetry frame checker; uses tfc_pkg and tfc_frame_track.
`timescale 1ns / 1ps

module telemetry_frame_checker_crc16_unit
    import tfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] payload_offset, [13:6] payload_byte,
                                   // [16:14] frame_status, [23:17] zero
    output logic        m_tuser,   // payload_valid
    output logic        m_tlast,   // frame_done
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data
);

    logic [7:0] sync_reg,    sync_next;
    logic [7:0] version_reg, version_next;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    logic       accept;

    // register writes
    always_comb
    begin
        sync_next    = sync_reg;
        version_next = version_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SYNC:    sync_next    = cfg_data;
                CFG_VERSION: version_next = cfg_data;
                default:     ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tfc_frame_track u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (s_tdata),
        .last_byte     (s_tlast),
        .sync_value    (sync_reg),
        .version_value (version_reg),
        .result        (result_next)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= SYNC_RESET;
            version_reg   <= VERSION_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sync_reg      <= sync_next;
            version_reg   <= version_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload holds only when not loaded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.payload_valid;
    assign m_tlast  = result_reg.frame_done;
    assign m_tdata  = {7'd0, result_reg.frame_status, result_reg.payload_byte,
                       result_reg.payload_offset};

`ifndef SYNTHESIS
    a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[16:14] == ST_OK)
        else $error("status given on an item that does not end a frame");

    a_payload_end_is_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tlast |-> m_tdata[16:14] == ST_SHORT)
        else $error("frame ending on a payload byte not reported short");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[5:0] <= POS_CRC_LAST - POS_PAYLOAD)
        else $error("payload offset out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result is stalled");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for telemetry_frame_checker_crc16_unit: builds telemetry frames
// (good, short, bad sync/version/CRC, trailing bytes, noise) and checks every result item.
// Depends on tfc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb_top;
    import tfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 120;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    typedef enum int {
        FK_GOOD,
        FK_SHORT,
        FK_BAD_SYNC,
        FK_BAD_VERSION,
        FK_BAD_CRC,
        FK_EXTRA,
        FK_NOISE
    } frame_kind_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we   = 1'b0;
    logic        cfg_addr = CFG_SYNC;
    logic [7:0]  cfg_data = 8'h00;

    rx_item_t    tx_bytes[$];
    rx_item_t    carry_bytes[$];
    result_t     want_results[$];
    rx_item_t    next_item;
    logic        quiet = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sent_count = 0;
    logic [7:0]  cur_sync;
    logic [7:0]  cur_ver;

    // frame tracker state, mirrors the block
    logic [7:0]  reg_sync;
    logic [7:0]  reg_ver;
    logic [5:0]  trk_count;
    logic [15:0] trk_crc;
    logic        trk_sync_ok;
    logic        trk_ver_ok;
    logic [15:0] trk_check;

    telemetry_frame_checker_crc16_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bit-serial CCITT update, MSB first
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        trk_count   = 6'd0;
        trk_crc     = CRC_INIT;
        trk_sync_ok = 1'b0;
        trk_ver_ok  = 1'b0;
        trk_check   = 16'h0000;
    endtask

    task automatic track_byte(input logic [7:0] b, input logic last);
        result_t r;
        r = '0;
        // bytes past the end of the frame change nothing unless they end the frame
        if (trk_count < FRAME_BYTES)
        begin
            if (trk_count == POS_SYNC)
                trk_sync_ok = (b == reg_sync);
            else if (trk_count == POS_VERSION)
                trk_ver_ok = (b == reg_ver);
            if (trk_count <= POS_CRC_LAST)
                trk_crc = crc_ccitt_step(trk_crc, b);
            if (trk_count >= POS_PAYLOAD && trk_count <= POS_CRC_LAST)
            begin
                r.payload_valid  = 1'b1;
                r.payload_offset = trk_count - POS_PAYLOAD;
                r.payload_byte   = b;
            end
            if (trk_count == POS_CHECK_LO)
                trk_check[7:0] = b;
            else if (trk_count == POS_CHECK_HI)
                trk_check[15:8] = b;
            trk_count = trk_count + 6'd1;
        end
        if (last)
        begin
            r.frame_done = 1'b1;
            if (trk_count < FRAME_BYTES)
                r.frame_status = ST_SHORT;
            else if (!trk_sync_ok)
                r.frame_status = ST_BAD_SYNC;
            else if (!trk_ver_ok)
                r.frame_status = ST_BAD_VERSION;
            else if (trk_crc != trk_check)
                r.frame_status = ST_BAD_CRC;
            else
                r.frame_status = ST_OK;
            clear_frame_state();
        end
        want_results.push_back(r);
    endtask

    // sender: config tracking, prediction on accept, bursty valid
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
            reg_sync = SYNC_RESET;
            reg_ver  = VERSION_RESET;
            clear_frame_state();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_SYNC)
                    reg_sync = cfg_data;
                else
                    reg_ver = cfg_data;
            end
            if (s_tvalid && s_tready)
                track_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (tx_bytes.size() != 0 && !quiet && $urandom_range(0, 9) == 0)
                begin
                    src_gap  <= $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    next_item = tx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tlast  <= next_item.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10)
            $display("[%0t] %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_result();
        result_t want;
        result_t got;
        got.payload_valid  = m_tuser;
        got.payload_offset = m_tdata[5:0];
        got.payload_byte   = m_tdata[13:6];
        got.frame_done     = m_tlast;
        got.frame_status   = status_t'(m_tdata[16:14]);
        if (want_results.size() == 0)
            note_mismatch("result item with nothing expected");
        else
        begin
            want = want_results.pop_front();
            if (got.payload_valid !== want.payload_valid
                || got.payload_offset !== want.payload_offset
                || got.payload_byte !== want.payload_byte
                || got.frame_done !== want.frame_done
                || got.frame_status !== want.frame_status)
                note_mismatch({
                    $sformatf("want v=%0d off=%0d byte=%02h done=%0d st=%0d, ",
                        want.payload_valid, want.payload_offset, want.payload_byte,
                        want.frame_done, want.frame_status),
                    $sformatf("got v=%0d off=%0d byte=%02h done=%0d st=%0d",
                        got.payload_valid, got.payload_offset, got.payload_byte,
                        got.frame_done, got.frame_status)});
        end
    endtask

    // receiver: check on accept, bursty ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (sink_gap != 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                sink_gap <= $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // split > 0 holds back the bytes from that position on for the next phase
    task automatic queue_frame(input frame_kind_t kind, input logic extremes, input int split);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          len;
        int          idx;
        rx_item_t    it;
        fb = {};
        fb.push_back(kind == FK_BAD_SYNC ? cur_sync ^ 8'($urandom_range(1, 255)) : cur_sync);
        if (kind == FK_BAD_VERSION || (kind == FK_BAD_SYNC && $urandom_range(0, 1) == 1))
            fb.push_back(cur_ver ^ 8'($urandom_range(1, 255)));
        else
            fb.push_back(cur_ver);
        for (int i = 0; i < 39; i++)
            fb.push_back(extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
        crc = CRC_INIT;
        foreach (fb[i])
            crc = crc_ccitt_step(crc, fb[i]);
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        case (kind)
            FK_BAD_CRC:
            begin
                idx = $urandom_range(2, 42);
                fb[idx] = fb[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            FK_SHORT:
            begin
                len = $urandom_range(1, 42);
                fb = fb[0:len-1];
            end
            FK_EXTRA:
                repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom_range(0, 255)));
            FK_NOISE:
            begin
                fb = {};
                repeat ($urandom_range(1, 60)) fb.push_back(8'($urandom_range(0, 255)));
            end
            default:
                ;
        endcase
        foreach (fb[i])
        begin
            it.data = fb[i];
            it.last = (i == fb.size() - 1);
            if (split != 0 && i >= split)
                carry_bytes.push_back(it);
            else
                tx_bytes.push_back(it);
        end
        sent_count += fb.size();
    endtask

    function automatic frame_kind_t pick_kind(input int n);
        int r;
        if (n < 7)
            return frame_kind_t'(n);
        r = $urandom_range(0, 9);
        case (r)
            4:       return FK_SHORT;
            5:       return FK_BAD_SYNC;
            6:       return FK_BAD_VERSION;
            7:       return FK_BAD_CRC;
            8:       return FK_EXTRA;
            9:       return FK_NOISE;
            default: return FK_GOOD;
        endcase
    endfunction

    // hold until the sender is empty and every result item is back
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_tvalid || want_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] sync_v, input logic [7:0] ver_v);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_SYNC;
        cfg_data <= sync_v;
        @(posedge clk);
        cfg_addr <= CFG_VERSION;
        cfg_data <= ver_v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_sync = sync_v;
        cur_ver  = ver_v;
    endtask

    initial
    begin
        int frame_idx;
        int phase_start;
        frame_idx = 0;
        cur_sync  = SYNC_RESET;
        cur_ver   = VERSION_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-byte frame, then a good frame with all-zero/all-one payload bytes
        tx_bytes.push_back('{data: 8'hFF, last: 1'b1});
        sent_count++;
        queue_frame(FK_GOOD, 1'b1, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p == 2 || p == PHASES - 1);
            if (p > 0)
            begin
                wait_drained();
                case (p)
                    1:       write_regs(8'h00, 8'h00);
                    2:       write_regs(8'hFF, 8'hFF);
                    5:       write_regs(SYNC_RESET, VERSION_RESET);
                    default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                endcase
                // finish the frame that was cut across the register write
                while (carry_bytes.size() != 0)
                    tx_bytes.push_back(carry_bytes.pop_front());
            end
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_BYTES)
            begin
                queue_frame(pick_kind(frame_idx), 1'b0, 0);
                frame_idx++;
            end
            if (p < PHASES - 1)
                queue_frame(pick_kind(7), 1'b0, $urandom_range(1, 3));
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
design/tfc_pkg.sv
design/tfc_frame_track.sv
design/telemetry_frame_checker_crc16_unit.sv
tb/sv/tb_top.sv
